FILE: rtl/deadline_frame_queue_assert.svh
// ----------------------------------------------------------------------------
// Deadline frame queue assertion macros
// Property wrappers shared by the queue's checks, clocked on clk with rst.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_FRAME_QUEUE_ASSERT_SVH
`define DEADLINE_FRAME_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deadline frame queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define DFQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deadline frame queue check failed");

`endif

FILE: rtl/dfq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline frame queue package
// Sizes, command codes and the stored entry layout of the frame queue.
// ----------------------------------------------------------------------------
package dfq_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int TAG_BITS   = 16;

  localparam int TIME_W  = 64;
  localparam int PTAG_W  = 16;
  localparam int CMD_W   = 3;
  localparam int CFG_W   = 5;
  localparam int STALE_W = 4;
  localparam int DROP_W  = 32;
  localparam int OCC_W   = 5;

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FILL_W = $clog2(MAX_FRAMES + 1);
  localparam int TAG_W  = (TAG_BITS < PTAG_W) ? TAG_BITS : PTAG_W;
  localparam int CMP_W  = (CFG_W > FILL_W) ? CFG_W : FILL_W;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_DUE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLOSE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic              is_end;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

FILE: rtl/deadline_frame_queue.sv
// Push steps through EXEC, SYNC and REPORT before the registered done strobe; pop
// front, clear, close, status and pop newest due on an empty queue or an end mark
// step through EXEC and REPORT; otherwise pop newest due also walks the due entries
// in WALK. An item can be accepted in the cycle that carries done, and none while
// busy, so each item holds the block until it is through. Results cannot be stalled.
// Synchronous reset empties and opens the queue; the entry store is not cleared.
// ----------------------------------------------------------------------------
// Deadline frame queue
// Bounded frame FIFO with a sequential walk that drops stale frames.
// ----------------------------------------------------------------------------
`include "deadline_frame_queue_assert.svh"

module deadline_frame_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dfq_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic [dfq_pkg::CMD_W-1:0]           command,
  input  logic signed [dfq_pkg::TIME_W-1:0]   frame_time,
  input  logic                                frame_is_end,
  input  logic [dfq_pkg::PTAG_W-1:0]          frame_tag,
  input  logic signed [dfq_pkg::TIME_W-1:0]   due_time,
  output logic                                accepted,
  output logic signed [dfq_pkg::TIME_W-1:0]   out_time,
  output logic                                out_is_end,
  output logic [dfq_pkg::PTAG_W-1:0]          out_tag,
  output logic [dfq_pkg::STALE_W-1:0]         stale_now,
  output logic [dfq_pkg::DROP_W-1:0]          drop_count,
  output logic [dfq_pkg::OCC_W-1:0]           occupancy,
  output logic                                head_time_valid,
  output logic signed [dfq_pkg::TIME_W-1:0]   head_time,
  output logic                                is_closed
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_SYNC,
    S_REPORT
  } state_t;

  state_t state, state_next;

  dfq_pkg::entry_t mem [dfq_pkg::MAX_FRAMES];
  dfq_pkg::entry_t rd_entry;
  dfq_pkg::entry_t wr_entry;

  logic [dfq_pkg::CFG_W-1:0]   cap_reg;
  logic [dfq_pkg::IDX_W-1:0]   head_index, head_next, head_inc, wr_slot;
  logic [dfq_pkg::FILL_W-1:0]  fill_count, fill_next, eff_cap;
  logic [dfq_pkg::DROP_W-1:0]  drop_total, drop_next, drop_sat;
  logic                        closed_flag, closed_next;
  logic [dfq_pkg::FILL_W-1:0]  popped, popped_next, popped_less;
  logic [dfq_pkg::STALE_W-1:0] stale_q, stale_next, stale_step;
  logic                        acc_q, acc_next;
  logic [dfq_pkg::TIME_W-1:0]  res_time, res_time_next;
  logic                        res_end, res_end_next;
  logic [dfq_pkg::TAG_W-1:0]   res_tag, res_tag_next;
  logic                        mem_we, walk_take;
  logic [dfq_pkg::FILL_W:0]    slot_sum;
  logic [dfq_pkg::DROP_W:0]    drop_sum;
  logic [dfq_pkg::CMP_W-1:0]   cap_wide;

  logic [dfq_pkg::CMD_W-1:0]   cmd_q;
  logic [dfq_pkg::TIME_W-1:0]  ftime_q, due_q;
  logic                        fend_q;
  logic [dfq_pkg::TAG_W-1:0]   ftag_q;

  assign busy = (state != S_IDLE);

  always_comb begin
    cap_wide = dfq_pkg::CMP_W'(cap_reg);
    if (cap_reg == '0) begin
      eff_cap = dfq_pkg::FILL_W'(1);
    end else if (cap_wide > dfq_pkg::CMP_W'(dfq_pkg::MAX_FRAMES)) begin
      eff_cap = dfq_pkg::FILL_W'(dfq_pkg::MAX_FRAMES);
    end else begin
      eff_cap = dfq_pkg::FILL_W'(cap_wide);
    end
  end

  assign head_inc = (head_index == dfq_pkg::IDX_W'(dfq_pkg::MAX_FRAMES - 1)) ?
                    '0 : head_index + 1'b1;

  always_comb begin
    slot_sum = (dfq_pkg::FILL_W + 1)'(head_index) + (dfq_pkg::FILL_W + 1)'(fill_count);
    if (slot_sum >= (dfq_pkg::FILL_W + 1)'(dfq_pkg::MAX_FRAMES)) begin
      slot_sum = slot_sum - (dfq_pkg::FILL_W + 1)'(dfq_pkg::MAX_FRAMES);
    end
    wr_slot = slot_sum[dfq_pkg::IDX_W-1:0];
  end

  assign walk_take = (fill_count != '0) && !rd_entry.is_end &&
                     ($signed(rd_entry.ts) <= $signed(due_q));

  always_comb begin
    popped_less = popped - 1'b1;
    if (popped_less > dfq_pkg::FILL_W'((1 << dfq_pkg::STALE_W) - 1)) begin
      stale_step = '1;
    end else begin
      stale_step = dfq_pkg::STALE_W'(popped_less);
    end
    drop_sum = {1'b0, drop_total} + (dfq_pkg::DROP_W + 1)'(popped_less);
    drop_sat = drop_sum[dfq_pkg::DROP_W] ? '1 : drop_sum[dfq_pkg::DROP_W-1:0];
  end

  assign wr_entry = '{ts: ftime_q, is_end: fend_q, tag: ftag_q};

  always_comb begin
    state_next    = state;
    head_next     = head_index;
    fill_next     = fill_count;
    drop_next     = drop_total;
    closed_next   = closed_flag;
    popped_next   = popped;
    stale_next    = stale_q;
    acc_next      = acc_q;
    res_time_next = res_time;
    res_end_next  = res_end;
    res_tag_next  = res_tag;
    mem_we        = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next    = S_EXEC;
          popped_next   = '0;
          stale_next    = '0;
          acc_next      = 1'b0;
          res_time_next = '0;
          res_end_next  = 1'b0;
          res_tag_next  = '0;
        end
      end
      S_EXEC: begin
        state_next = S_REPORT;
        case (cmd_q)
          dfq_pkg::CMD_PUSH: begin
            state_next = S_SYNC;
            if (!closed_flag && (fill_count < eff_cap)) begin
              mem_we    = 1'b1;
              fill_next = fill_count + 1'b1;
              acc_next  = 1'b1;
            end
          end
          dfq_pkg::CMD_POP: begin
            if (fill_count != '0) begin
              acc_next      = 1'b1;
              res_time_next = rd_entry.ts;
              res_end_next  = rd_entry.is_end;
              res_tag_next  = rd_entry.tag;
              head_next     = head_inc;
              fill_next     = fill_count - 1'b1;
            end
          end
          dfq_pkg::CMD_POP_DUE: begin
            if (fill_count != '0) begin
              if (rd_entry.is_end) begin
                acc_next      = 1'b1;
                res_time_next = rd_entry.ts;
                res_end_next  = 1'b1;
                res_tag_next  = rd_entry.tag;
                head_next     = head_inc;
                fill_next     = fill_count - 1'b1;
              end else begin
                state_next = S_WALK;
              end
            end
          end
          dfq_pkg::CMD_CLEAR: begin
            fill_next = '0;
            head_next = '0;
            drop_next = '0;
          end
          dfq_pkg::CMD_CLOSE: begin
            closed_next = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        if (walk_take) begin
          res_time_next = rd_entry.ts;
          res_tag_next  = rd_entry.tag;
          head_next     = head_inc;
          fill_next     = fill_count - 1'b1;
          popped_next   = popped + 1'b1;
        end else begin
          state_next = S_REPORT;
          if (popped != '0) begin
            acc_next   = 1'b1;
            stale_next = stale_step;
            drop_next  = drop_sat;
          end
        end
      end
      S_SYNC: begin
        state_next = S_REPORT;
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_slot] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cap_reg     <= dfq_pkg::CAP_RESET;
      head_index  <= '0;
      fill_count  <= '0;
      drop_total  <= '0;
      closed_flag <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      head_index  <= head_next;
      fill_count  <= fill_next;
      drop_total  <= drop_next;
      closed_flag <= closed_next;
      done        <= (state == S_REPORT);
      if (cfg_we) begin
        cap_reg <= cfg_wdata;
      end
    end
    popped   <= popped_next;
    stale_q  <= stale_next;
    acc_q    <= acc_next;
    res_time <= res_time_next;
    res_end  <= res_end_next;
    res_tag  <= res_tag_next;
    if ((state == S_IDLE) && start) begin
      cmd_q   <= command;
      ftime_q <= frame_time;
      fend_q  <= frame_is_end;
      ftag_q  <= dfq_pkg::TAG_W'(frame_tag);
      due_q   <= due_time;
    end
    if (state == S_REPORT) begin
      accepted        <= acc_q;
      out_time        <= res_time;
      out_is_end      <= res_end;
      out_tag         <= dfq_pkg::PTAG_W'(res_tag);
      stale_now       <= stale_q;
      drop_count      <= drop_total;
      occupancy       <= dfq_pkg::OCC_W'(fill_count);
      is_closed       <= closed_flag;
      head_time_valid <= (fill_count != '0) && !rd_entry.is_end;
      head_time       <= ((fill_count != '0) && !rd_entry.is_end) ? rd_entry.ts : '0;
    end
  end

  `DFQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= dfq_pkg::FILL_W'(dfq_pkg::MAX_FRAMES))
  `DFQ_ASSERT_NEXT(a_report_done, state == S_REPORT, done && !busy)
  `DFQ_ASSERT_NEXT(a_walk_take, (state == S_WALK) && walk_take,
                   fill_count == $past(fill_count) - 1'b1)
  `DFQ_ASSERT_NOW(a_head_zero, done && !head_time_valid, head_time == '0)

endmodule
